### rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg: shared definitions for the generational slot table
// Field widths, request and status codes, sequencer and pending-slot types.
// ----------------------------------------------------------------------------
package gst_pkg;

  // Default table depth and the slot count loaded at reset
  localparam int DEF_MAX_SLOTS = 64;
  localparam int RESET_SLOTS   = 64;

  // Item field widths
  localparam int MODE_W     = 2;
  localparam int OBJ_W      = 32;
  localparam int SLOT_IDX_W = 6;
  localparam int ID_W       = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 7;

  // Packed stream widths (fields padded to whole bytes)
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_REG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNREG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  // Free-slot hint: not known, table known full, or a known free slot
  typedef enum logic [1:0] {
    PEND_UNKNOWN = 2'd0,
    PEND_FULL    = 2'd1,
    PEND_SLOT    = 2'd2
  } pend_t;

endpackage

### rtl/gst_slot_ram.sv
// ----------------------------------------------------------------------------
// gst_slot_ram: per-slot object and id storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gst_slot_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/generational_slot_table.sv
// Steps: register with a known free slot grants it, then loads m_tvalid; a
//   register that searches scans first (one occupancy probe per cycle).
// Unregister, lookup: RAM read, compare, output load; full/bad mode: output load.
// Throughput: one item at a time; s_tready returns once the result is in the
//   output register, which waits for m_tready. Worst case is set by the free-slot scan.
// Reset (rst, synchronous) and every cfg_wen write clear the table at once.
// ----------------------------------------------------------------------------
// generational_slot_table: slot table handing out (slot, running id) handles
// Register takes a remembered free slot or searches one from the last one given;
// unregister and lookup check slot range, occupancy and stored id (unregister also the object).
// ----------------------------------------------------------------------------
module generational_slot_table
  import gst_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: slots_in_use
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // object_handle[31:0], slot_index[37:32],
                                           // entry_id[69:38], zero pad[71:70]
  input  logic [MODE_W-1:0]     s_tuser,   // mode[1:0]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // given_slot[5:0], given_id[37:6],
                                           // found_object[69:38], zero pad[71:70]
  output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = ($clog2(MAX_SLOTS + 1) > CFG_W) ? $clog2(MAX_SLOTS + 1) : CFG_W;
  localparam int AX_W   = (SLOT_W > SLOT_IDX_W) ? SLOT_W : SLOT_IDX_W;
  localparam int RAM_W  = OBJ_W + ID_W;
  localparam logic [CNT_W-1:0] N_MAX   = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0] N_RESET = (MAX_SLOTS < RESET_SLOTS) ? N_MAX
                                                                   : CNT_W'(RESET_SLOTS);

  // Input fields
  logic [MODE_W-1:0]     in_mode;
  logic [OBJ_W-1:0]      in_obj;
  logic [SLOT_IDX_W-1:0] in_slot;
  logic [ID_W-1:0]       in_id;

  assign in_mode = s_tuser;
  assign in_obj  = s_tdata[OBJ_W-1:0];
  assign in_slot = s_tdata[OBJ_W+SLOT_IDX_W-1:OBJ_W];
  assign in_id   = s_tdata[OBJ_W+SLOT_IDX_W+ID_W-1:OBJ_W+SLOT_IDX_W];

  // State
  state_t                state, state_next;
  logic [CNT_W-1:0]      slots_in_use;
  logic [MAX_SLOTS-1:0]  occupied;
  pend_t                 pend, pend_next;
  logic [SLOT_W-1:0]     pend_slot, pend_slot_next;
  logic [SLOT_W-1:0]     last_slot, last_slot_next;
  logic [ID_W-1:0]       id_counter, id_counter_next;

  // Scan pointer and step count
  logic [SLOT_W-1:0]     scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0]      scan_cnt, scan_cnt_next;

  // Latched request
  logic [MODE_W-1:0]     req_mode, req_mode_next;
  logic [OBJ_W-1:0]      req_obj, req_obj_next;
  logic [SLOT_IDX_W-1:0] req_slot, req_slot_next;
  logic [ID_W-1:0]       req_id, req_id_next;

  // Pending result
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [SLOT_IDX_W-1:0] res_slot, res_slot_next;
  logic [ID_W-1:0]       res_id, res_id_next;
  logic [OBJ_W-1:0]      res_obj, res_obj_next;

  // Sequencer actions
  logic                  alloc_en;
  logic [SLOT_W-1:0]     alloc_slot;
  logic                  free_en;
  logic                  rd_en;
  logic                  out_free;

  // Address views of the slot fields
  logic [AX_W-1:0]       in_slot_ax, req_slot_ax, alloc_slot_ax;
  logic [SLOT_W-1:0]     in_addr, req_addr;
  logic                  req_in_range;
  logic                  req_hit;
  logic [RAM_W-1:0]      rd_data;
  logic [OBJ_W-1:0]      rd_obj;
  logic [ID_W-1:0]       rd_id;
  logic [CNT_W-1:0]      cfg_ext, cfg_clamped;

  assign in_slot_ax    = AX_W'(in_slot);
  assign req_slot_ax   = AX_W'(req_slot);
  assign alloc_slot_ax = AX_W'(alloc_slot);
  assign in_addr       = in_slot_ax[SLOT_W-1:0];
  assign req_addr      = req_slot_ax[SLOT_W-1:0];
  assign req_in_range  = CNT_W'(req_slot) < slots_in_use;
  assign rd_obj        = rd_data[OBJ_W-1:0];
  assign rd_id         = rd_data[RAM_W-1:OBJ_W];
  assign req_hit       = req_in_range && occupied[req_addr] && (rd_id == req_id);

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Clamp the written slot count to 1..MAX_SLOTS
  assign cfg_ext = CNT_W'(cfg_wdata);
  always_comb begin
    cfg_clamped = cfg_ext;
    if (cfg_ext == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_ext > N_MAX) begin
      cfg_clamped = N_MAX;
    end
  end

  // Object/id storage
  gst_slot_ram #(
    .DEPTH  (MAX_SLOTS),
    .WIDTH  (RAM_W),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (alloc_en),
    .wr_addr (alloc_slot),
    .wr_data ({id_counter, req_obj_next}),
    .rd_en   (rd_en),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_comb begin
    state_next      = state;
    pend_next       = pend;
    pend_slot_next  = pend_slot;
    last_slot_next  = last_slot;
    id_counter_next = id_counter;
    scan_ptr_next   = scan_ptr;
    scan_cnt_next   = scan_cnt;
    req_mode_next   = req_mode;
    req_obj_next    = req_obj;
    req_slot_next   = req_slot;
    req_id_next     = req_id;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_id_next     = res_id;
    res_obj_next    = res_obj;
    alloc_en        = 1'b0;
    alloc_slot      = '0;
    free_en         = 1'b0;
    rd_en           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          req_mode_next = in_mode;
          req_obj_next  = in_obj;
          req_slot_next = in_slot;
          req_id_next   = in_id;
          if (in_mode == MODE_REG) begin
            priority case (pend)
              PEND_UNKNOWN: begin
                scan_ptr_next = last_slot;
                scan_cnt_next = '0;
                state_next    = ST_SEARCH;
              end
              PEND_SLOT: begin
                alloc_en   = 1'b1;
                alloc_slot = pend_slot;
              end
              default: begin
                // table known full
                res_status_next = STAT_FULL;
                res_slot_next   = '0;
                res_id_next     = '0;
                res_obj_next    = '0;
                state_next      = ST_DONE;
              end
            endcase
          end else if (in_mode == MODE_UNREG || in_mode == MODE_LOOKUP) begin
            rd_en      = 1'b1;
            state_next = ST_CHECK;
          end else begin
            // unused mode: echo, not found
            res_status_next = STAT_NOTFOUND;
            res_slot_next   = in_slot;
            res_id_next     = in_id;
            res_obj_next    = '0;
            state_next      = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        // one occupancy probe per cycle, wrapping at slots_in_use
        if (!occupied[scan_ptr]) begin
          alloc_en   = 1'b1;
          alloc_slot = scan_ptr;
        end else if (scan_cnt == slots_in_use - CNT_W'(1)) begin
          pend_next       = PEND_FULL;
          res_status_next = STAT_FULL;
          res_slot_next   = '0;
          res_id_next     = '0;
          res_obj_next    = '0;
          state_next      = ST_DONE;
        end else begin
          scan_cnt_next = scan_cnt + CNT_W'(1);
          if (CNT_W'(scan_ptr) + CNT_W'(1) == slots_in_use) begin
            scan_ptr_next = '0;
          end else begin
            scan_ptr_next = scan_ptr + SLOT_W'(1);
          end
        end
      end
      ST_CHECK: begin
        res_slot_next   = req_slot;
        res_id_next     = req_id;
        res_obj_next    = '0;
        res_status_next = STAT_NOTFOUND;
        if (req_mode == MODE_UNREG) begin
          if (req_hit && (rd_obj == req_obj)) begin
            free_en         = 1'b1;
            res_status_next = STAT_OK;
            if (pend == PEND_FULL) begin
              pend_next      = PEND_SLOT;
              pend_slot_next = req_addr;
            end
          end
        end else if (req_hit) begin
          res_status_next = STAT_OK;
          res_obj_next    = rd_obj;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Slot grant
    if (alloc_en) begin
      last_slot_next  = alloc_slot;
      id_counter_next = id_counter + ID_W'(1);
      pend_next       = PEND_UNKNOWN;
      res_status_next = STAT_OK;
      res_slot_next   = alloc_slot_ax[SLOT_IDX_W-1:0];
      res_id_next     = id_counter;
      res_obj_next    = '0;
      state_next      = ST_DONE;
    end
  end

  // Control registers; a config write reinitializes the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= N_RESET;
      occupied     <= '0;
      pend         <= PEND_UNKNOWN;
      last_slot    <= '0;
      id_counter   <= '0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      last_slot  <= last_slot_next;
      id_counter <= id_counter_next;
      if (alloc_en) begin
        occupied[alloc_slot] <= 1'b1;
      end else if (free_en) begin
        occupied[req_addr] <= 1'b0;
      end
      if (cfg_wen) begin
        slots_in_use <= cfg_clamped;
        occupied     <= '0;
        pend         <= PEND_UNKNOWN;
        last_slot    <= '0;
        id_counter   <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pend_slot  <= pend_slot_next;
    scan_ptr   <= scan_ptr_next;
    scan_cnt   <= scan_cnt_next;
    req_mode   <= req_mode_next;
    req_obj    <= req_obj_next;
    req_slot   <= req_slot_next;
    req_id     <= req_id_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_id     <= res_id_next;
    res_obj    <= res_obj_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= OUT_DATA_W'({res_obj, res_id, res_slot});
      m_tuser <= res_status;
    end
  end

`ifndef SYNTHESIS
  // A granted slot is marked occupied
  assert property (@(posedge clk) disable iff (rst)
    (alloc_en && !cfg_wen) |=> occupied[$past(alloc_slot)])
    else $error("granted slot not marked occupied");

  // Each grant advances the running id by one
  assert property (@(posedge clk) disable iff (rst)
    (alloc_en && !cfg_wen) |=> (id_counter == $past(id_counter) + ID_W'(1)))
    else $error("running id did not advance on grant");

  // A remembered free slot really is free
  assert property (@(posedge clk) disable iff (rst)
    (pend == PEND_SLOT) |-> !occupied[pend_slot])
    else $error("remembered free slot is occupied");

  // The scan never takes more steps than slots in use
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (scan_cnt < slots_in_use))
    else $error("free-slot scan overran");

  // A compare step always produces a result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> (state == ST_DONE))
    else $error("compare step did not produce a result");
`endif

endmodule
